// File: design/ir_pulse_width_code_decoder_macros.svh
// Assertion macros for the IR pulse width code decoder.
// Each use expands to one labelled concurrent assertion on clk, held off during rst.
`ifndef IR_PULSE_WIDTH_CODE_DECODER_MACROS_SVH
`define IR_PULSE_WIDTH_CODE_DECODER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IPWD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define IPWD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ipwd_pkg.sv
package ipwd_pkg;

  localparam int CHANNELS   = 4;
  localparam int CH_W       = 2;
  localparam int CODE_W     = 4;
  localparam int TICK_W     = 8;
  localparam int SHIFT_W    = 3;
  localparam int BITS_W     = 2;

  localparam logic [CODE_W-1:0]  NO_SIGNAL  = 4'd8;
  localparam logic [BITS_W-1:0]  FRAME_BITS = 2'd3;
  localparam logic [TICK_W-1:0]  TICK_MAX   = 8'd255;

  localparam logic [TICK_W-1:0]  START_MIN_RST = 8'd120;
  localparam logic [TICK_W-1:0]  ONE_MIN_RST   = 8'd60;
  localparam logic [TICK_W-1:0]  ZERO_MIN_RST  = 8'd30;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_MIN = 2'd0,
    REG_ONE_MIN   = 2'd1,
    REG_ZERO_MIN  = 2'd2
  } ipwd_reg_t;

  // decoded store command handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic              wr;
    logic [CODE_W-1:0] wval;
    logic              done;
  } ipwd_cmd_t;

endpackage

// File: design/ipwd_front.sv
module ipwd_front
  import ipwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TICK_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  line_level,
  input  logic [CH_W-1:0]       channel,
  input  logic                  window_start,
  input  logic                  active,
  input  logic                  q_full,
  output logic                  push,
  output ipwd_cmd_t             cmd
);

  logic [TICK_W-1:0]  start_min, one_min, zero_min;
  logic [TICK_W-1:0]  low_ticks, low_ticks_next;
  logic               prev_level, prev_level_next;
  logic               in_frame, in_frame_next;
  logic [BITS_W-1:0]  bits_seen, bits_seen_next;
  logic [SHIFT_W-1:0] shift_bits, shift_bits_next;
  logic               done;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    low_ticks_next  = low_ticks;
    prev_level_next = prev_level;
    in_frame_next   = in_frame;
    bits_seen_next  = bits_seen;
    shift_bits_next = shift_bits;
    done            = 1'b0;
    if (window_start) begin
      low_ticks_next  = '0;
      in_frame_next   = 1'b0;
      bits_seen_next  = '0;
      shift_bits_next = '0;
      prev_level_next = line_level;
    end else if (active) begin
      if (!line_level) begin
        if (prev_level) begin
          low_ticks_next = TICK_W'(1);
        end else if (low_ticks != TICK_MAX) begin
          low_ticks_next = low_ticks + TICK_W'(1);
        end
      end else if (!prev_level) begin
        if (!in_frame && low_ticks >= start_min) begin
          in_frame_next  = 1'b1;
          bits_seen_next = '0;
        end else if (in_frame && low_ticks >= one_min) begin
          shift_bits_next = {1'b1, shift_bits[SHIFT_W-1:1]};
          bits_seen_next  = bits_seen + BITS_W'(1);
        end else if (in_frame && low_ticks >= zero_min) begin
          shift_bits_next = {1'b0, shift_bits[SHIFT_W-1:1]};
          bits_seen_next  = bits_seen + BITS_W'(1);
        end
        if (bits_seen_next >= FRAME_BITS) begin
          in_frame_next  = 1'b0;
          bits_seen_next = '0;
          done           = 1'b1;
        end
        low_ticks_next = '0;
      end
      prev_level_next = line_level;
    end
  end

  always_comb begin
    cmd.channel = channel;
    cmd.done    = done;
    cmd.wr      = window_start || done;
    cmd.wval    = window_start ? NO_SIGNAL : {1'b0, shift_bits_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_min  <= START_MIN_RST;
      one_min    <= ONE_MIN_RST;
      zero_min   <= ZERO_MIN_RST;
      low_ticks  <= '0;
      prev_level <= 1'b1;
      in_frame   <= 1'b0;
      bits_seen  <= '0;
      shift_bits <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_START_MIN: start_min <= cfg_wdata;
          REG_ONE_MIN:   one_min   <= cfg_wdata;
          REG_ZERO_MIN:  zero_min  <= cfg_wdata;
          default: ;
        endcase
      end
      if (push) begin
        low_ticks  <= low_ticks_next;
        prev_level <= prev_level_next;
        in_frame   <= in_frame_next;
        bits_seen  <= bits_seen_next;
        shift_bits <= shift_bits_next;
      end
    end
  end

endmodule

// File: design/ipwd_queue.sv
module ipwd_queue
  import ipwd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  ipwd_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output ipwd_cmd_t head
);

  ipwd_cmd_t          entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/ipwd_back.sv
module ipwd_back
  import ipwd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ipwd_cmd_t         head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_channel,
  output logic [CODE_W-1:0] code,
  output logic              code_done
);

  logic [CODE_W-1:0] code_store [CHANNELS];

  assign pop = !q_empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        code_store[i] <= NO_SIGNAL;
      end
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        if (head.wr) begin
          code_store[head.channel] <= head.wval;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop) begin
      out_channel <= head.channel;
      code        <= head.wr ? head.wval : code_store[head.channel];
      code_done   <= head.done;
    end
  end

endmodule

// File: design/ir_pulse_width_code_decoder.sv
// IR pulse width code decoder.
// Input stream: one line sample per timer tick. s_tdata = {pad, channel, line_level},
// s_tuser = {active, window_start}. Each transfer yields exactly one result.
// Output stream: m_tdata = {pad, code, out_channel}, m_tuser = code_done.
// code is the stored code of the channel (0..7, 8 = no signal) after this sample.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the start, one and zero pulse
// thresholds; write only while the block is idle.
// The result of a transferred sample goes through the queue and is then registered in
// the back end's output register and shown on m_tvalid when the output is free.
// Throughput: one sample per cycle while s_tready is high; the decoder front updates its pulse state in
// the transfer cycle and passes a store command through a 4-entry queue to the
// back end, which updates the per-channel code store and registers the result.
// When m_tready is low the queue fills and s_tready drops once it holds four
// entries; nothing is lost. Reset restores the thresholds to 120/60/30,
// clears the pulse state (line taken as idle high), empties the queue and sets
// every channel to no signal.
module ir_pulse_width_code_decoder
  import ipwd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [TICK_W-1:0]     cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // line_level, channel[1:0], zero pad
  input  logic [1:0]            s_tuser,   // window_start, active
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_channel[1:0], code[3:0], zero pad
  output logic                  m_tuser    // code_done
);

  `include "ir_pulse_width_code_decoder_macros.svh"

  logic              push, pop, q_full, q_empty;
  ipwd_cmd_t         cmd, head;
  logic [CH_W-1:0]   out_channel;
  logic [CODE_W-1:0] code;

  ipwd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .line_level   (s_tdata[0]),
    .channel      (s_tdata[2:1]),
    .window_start (s_tuser[0]),
    .active       (s_tuser[1]),
    .q_full       (q_full),
    .push         (push),
    .cmd          (cmd)
  );

  ipwd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  ipwd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_channel (out_channel),
    .code        (code),
    .code_done   (m_tuser)
  );

  assign m_tdata = {2'b00, code, out_channel};

  `IPWD_ASSERT_IMP(a_no_push_full, push, !q_full, "push into full queue")
  `IPWD_ASSERT_IMP(a_done_writes, push && cmd.done, cmd.wr && !cmd.wval[3], "bad done cmd")
  `IPWD_ASSERT_IMP(a_done_code, m_tvalid && m_tuser, !m_tdata[5], "done with no-signal code")
  `IPWD_ASSERT_NXT(a_pop_valid, pop, m_tvalid, "pop without output valid")

endmodule
